/* hw/rtl/mwac_pkg.sv */
// shared types and constants of the median and weighted average adc conditioner
package mwac_pkg;

  localparam int unsigned RAW_W       = 12;
  localparam int unsigned SMOOTH_W    = 16;
  localparam int unsigned MV_W        = 16;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned WSUM_W      = 10;
  localparam int unsigned FS_W        = 12;
  localparam int unsigned NUM_WEIGHTS = 4;
  localparam int unsigned ACC_W       = 32;

  localparam int unsigned DIV_NUM_W  = 32;
  localparam int unsigned DIV_DEN_W  = 16;
  localparam int unsigned DIV_Q_W    = 16;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_Q_W);

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_OLDEST = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_THIRD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_NEWEST = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REFERENCE_MV  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_MV        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_MV        = 3'd7;

  typedef struct packed {
    logic lt;
    logic le;
  } cmp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/mwac_cell.sv */
// one cell of the median window row: holds a sample and compares it with the candidate
module mwac_cell import mwac_pkg::*; #(
  parameter int unsigned SW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [SW-1:0] d_i,
  input  logic [SW-1:0] cand_i,
  output logic [SW-1:0] q_o,
  output cmp_t          cmp_o
);

  logic [SW-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o       = val_q;
  assign cmp_o.lt  = (val_q < cand_i);
  assign cmp_o.le  = (val_q <= cand_i);

endmodule

/* hw/rtl/mwac_median.sv */
// sliding median stage: a ring of cells rotated past a rank counter
module mwac_median import mwac_pkg::*; #(
  parameter int unsigned TAPS = 5,
  parameter int unsigned SW   = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] sample_i,
  output logic          done_o,
  output logic [SW-1:0] median_o
);

  localparam int unsigned CW = $clog2(TAPS + 1);
  localparam int unsigned RW = $clog2(TAPS);
  localparam logic [CW-1:0] MID  = CW'(TAPS / 2);
  localparam logic [RW-1:0] LAST = RW'(TAPS - 1);

  logic [SW-1:0] val    [TAPS];
  logic [SW-1:0] cell_d [TAPS];
  cmp_t          cmp    [TAPS];
  logic          cell_en;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW-1:0] rot_q, rot_d;
  logic [RW-1:0] fill_q, fill_d;
  logic          full_q, full_d;
  logic          use_q, use_d;
  logic [SW-1:0] samp_q, samp_d;
  logic [SW-1:0] found_q, found_d;
  logic [CW-1:0] lt_cnt, le_cnt;

  assign cell_en = start_i | busy_q;

  always_comb begin
    cell_d[0] = start_i ? sample_i : val[TAPS-1];
    for (int i = 1; i < TAPS; i++) begin
      cell_d[i] = val[i-1];
    end
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    mwac_cell #(.SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (cell_en),
      .d_i    (cell_d[g]),
      .cand_i (val[0]),
      .q_o    (val[g]),
      .cmp_o  (cmp[g])
    );
  end

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < TAPS; j++) begin
      lt_cnt = lt_cnt + CW'(cmp[j].lt);
      le_cnt = le_cnt + CW'(cmp[j].le);
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    rot_d   = rot_q;
    fill_d  = fill_q;
    full_d  = full_q;
    use_d   = use_q;
    samp_d  = samp_q;
    found_d = found_q;
    if (start_i) begin
      samp_d = sample_i;
      busy_d = 1'b1;
      rot_d  = '0;
      if (fill_q == LAST) begin
        fill_d = '0;
        full_d = 1'b1;
        use_d  = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
        use_d  = full_q;
      end
    end else if (busy_q) begin
      if ((lt_cnt <= MID) && (le_cnt > MID)) begin
        found_d = val[0];
      end
      if (rot_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rot_d = rot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rot_q  <= '0;
      fill_q <= '0;
      full_q <= 1'b0;
      use_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rot_q  <= rot_d;
      fill_q <= fill_d;
      full_q <= full_d;
      use_q  <= use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q  <= samp_d;
    found_q <= found_d;
  end

  assign done_o   = done_q;
  assign median_o = use_q ? found_q : samp_q;

endmodule

/* hw/rtl/mwac_div.sv */
// shared restoring divider with 16-bit saturated quotient, one bit per cycle
module mwac_div import mwac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [DIV_DEN_W-1:0]  den_q, den_d;
  logic [DIV_DEN_W-1:0]  rem_q, rem_d;
  logic [DIV_Q_W-1:0]    work_q, work_d;
  logic [DIV_DEN_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q, work_q[DIV_Q_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    den_d  = den_q;
    rem_d  = rem_q;
    work_d = work_q;
    if (req_i.start) begin
      den_d = req_i.den;
      priority if (req_i.den == '0) begin
        work_d = '0;
        done_d = 1'b1;
      end else if (req_i.num[DIV_NUM_W-1:DIV_Q_W] >= req_i.den) begin
        work_d = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = req_i.num[DIV_NUM_W-1:DIV_Q_W];
        work_d = req_i.num[DIV_Q_W-1:0];
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (busy_q) begin
      rem_d  = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      work_d = {work_q[DIV_Q_W-2:0], ge};
      if (step_q == DIV_STEP_W'(DIV_Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    work_q <= work_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q;

endmodule

/* hw/rtl/median_wma_adc_conditioner_top.sv */
// top level: median stage, weighted moving average, millivolt scaling and clamp
//
// Takes one converter sample per word and returns one word with the sample, the
// sliding median (the sample itself until the median window has filled once), the
// weighted moving average with four fraction bits (plain mean until the average
// window has filled once) and the clamped voltage in millivolts. One word is in
// work at a time and passes through these steps in order: the median ring is rotated
// past the rank counter, each average tap is weighted and accumulated in turn, and
// then two passes of up to 16 steps run on the shared bit-serial divider. A
// finished word waits in the output register while the next sample is taken. The
// eight configuration registers sit at byte addresses 0x00 to 0x1c and are to be
// written by the user only while the block is idle; the block does not enforce it.
module median_wma_adc_conditioner_top import mwac_pkg::*; #(
  parameter int unsigned MEDIAN_TAPS  = 5,
  parameter int unsigned AVERAGE_TAPS = 4,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RAW_W-1:0]      raw_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RAW_W-1:0]      raw_echo_o,
  output logic [RAW_W-1:0]      median_value_o,
  output logic [SMOOTH_W-1:0]   smoothed_value_o,
  output logic [MV_W-1:0]       voltage_mv_o
);

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned EW = SAMPLE_BITS + 4;
  localparam int unsigned KW = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(AVERAGE_TAPS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MED  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_VMUL = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // configuration
  logic [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];
  logic [FS_W-1:0]     fs_q;
  logic [MV_W-1:0]     ref_q;
  logic [MV_W-1:0]     min_q;
  logic [MV_W-1:0]     max_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q[0] <= 8'd1;
      weight_q[1] <= 8'd2;
      weight_q[2] <= 8'd3;
      weight_q[3] <= 8'd4;
      fs_q        <= 12'd4095;
      ref_q       <= 16'd3300;
      min_q       <= 16'd0;
      max_q       <= 16'd3300;
    end else if (cfg_wr) begin
      unique case (paddr[APB_ADDR_W-1:2])
        REG_WEIGHT_OLDEST: weight_q[0] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_SECOND: weight_q[1] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_THIRD:  weight_q[2] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_NEWEST: weight_q[3] <= pwdata[WEIGHT_W-1:0];
        REG_FULL_SCALE:    fs_q        <= pwdata[FS_W-1:0];
        REG_REFERENCE_MV:  ref_q       <= pwdata[MV_W-1:0];
        REG_MIN_MV:        min_q       <= pwdata[MV_W-1:0];
        REG_MAX_MV:        max_q       <= pwdata[MV_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:2])
      REG_WEIGHT_OLDEST: prdata = APB_DATA_W'(weight_q[0]);
      REG_WEIGHT_SECOND: prdata = APB_DATA_W'(weight_q[1]);
      REG_WEIGHT_THIRD:  prdata = APB_DATA_W'(weight_q[2]);
      REG_WEIGHT_NEWEST: prdata = APB_DATA_W'(weight_q[3]);
      REG_FULL_SCALE:    prdata = APB_DATA_W'(fs_q);
      REG_REFERENCE_MV:  prdata = APB_DATA_W'(ref_q);
      REG_MIN_MV:        prdata = APB_DATA_W'(min_q);
      REG_MAX_MV:        prdata = APB_DATA_W'(max_q);
    endcase
  end

  // datapath and sequencer
  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       sample;
  logic [SW-1:0]       samp_q, samp_d;
  logic [SW-1:0]       med_val_q, med_val_d;
  logic [EW-1:0]       aw_q [AVERAGE_TAPS];
  logic [EW-1:0]       aw_d [AVERAGE_TAPS];
  logic [KW-1:0]       acnt_q, acnt_d;
  logic                afull_q, afull_d;
  logic [KW-1:0]       k_q, k_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic [SMOOTH_W-1:0] smooth_q, smooth_d;
  logic [ACC_W-1:0]    vprod_q, vprod_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic                div_go_q, div_go_d;
  logic                out_valid_q, out_valid_d;
  logic [RAW_W-1:0]    out_raw_q, out_raw_d;
  logic [RAW_W-1:0]    out_med_q, out_med_d;
  logic [SMOOTH_W-1:0] out_smooth_q, out_smooth_d;
  logic [MV_W-1:0]     out_mv_q, out_mv_d;

  logic                accept;
  logic                med_done;
  logic [SW-1:0]       med_out;
  logic [WEIGHT_W-1:0] weff;
  logic [1:0]          widx;
  logic [EW+WEIGHT_W-1:0] term;
  logic [FS_W-1:0]     fs_eff;
  logic [MV_W-1:0]     mv_raw;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign sample     = SW'(raw_sample_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign fs_eff     = (fs_q == '0) ? FS_W'(1) : fs_q;
  assign widx       = 2'(NUM_WEIGHTS - 1) - 2'(k_q);

  mwac_median #(.TAPS(MEDIAN_TAPS), .SW(SW)) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (sample),
    .done_o   (med_done),
    .median_o (med_out)
  );

  always_comb begin
    div_req.start = div_go_q;
    if (state_q == S_DIV1) begin
      div_req.num = acc_q;
      div_req.den = afull_q ? DIV_DEN_W'(wsum_q) : DIV_DEN_W'(acnt_q);
    end else begin
      div_req.num = vprod_q;
      div_req.den = {fs_eff, 4'b0000};
    end
  end

  mwac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (afull_q) begin
      weff = weight_q[widx];
    end else begin
      weff = (k_q < acnt_q) ? WEIGHT_W'(1) : '0;
    end
    term = (EW + WEIGHT_W)'(aw_q[k_q]) * (EW + WEIGHT_W)'(weff);
  end

  always_comb begin
    mv_raw = div_rsp.quot;
    priority if (mv_raw < min_q) begin
      mv_raw = min_q;
    end else if (mv_raw > max_q) begin
      mv_raw = max_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    samp_d       = samp_q;
    med_val_d    = med_val_q;
    aw_d         = aw_q;
    acnt_d       = acnt_q;
    afull_d      = afull_q;
    k_d          = k_q;
    acc_d        = acc_q;
    wsum_d       = wsum_q;
    smooth_d     = smooth_q;
    vprod_d      = vprod_q;
    mv_d         = mv_q;
    div_go_d     = 1'b0;
    out_valid_d  = out_valid_q & out_stall_i;
    out_raw_d    = out_raw_q;
    out_med_d    = out_med_q;
    out_smooth_d = out_smooth_q;
    out_mv_d     = out_mv_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          samp_d  = sample;
          state_d = S_MED;
        end
      end
      S_MED: begin
        if (med_done) begin
          med_val_d = med_out;
          aw_d[0]   = {med_out, 4'b0000};
          for (int i = 1; i < AVERAGE_TAPS; i++) begin
            aw_d[i] = aw_q[i-1];
          end
          if (acnt_q == K_LAST) begin
            acnt_d  = '0;
            afull_d = 1'b1;
          end else begin
            acnt_d = acnt_q + 1'b1;
          end
          k_d     = '0;
          acc_d   = '0;
          wsum_d  = '0;
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        acc_d  = acc_q + ACC_W'(term);
        wsum_d = wsum_q + WSUM_W'(weff);
        if (k_q == K_LAST) begin
          div_go_d = 1'b1;
          state_d  = S_DIV1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          smooth_d = div_rsp.quot;
          state_d  = S_VMUL;
        end
      end
      S_VMUL: begin
        vprod_d  = ACC_W'(smooth_q) * ACC_W'(ref_q);
        div_go_d = 1'b1;
        state_d  = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          mv_d    = mv_raw;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_raw_d    = RAW_W'(samp_q);
          out_med_d    = RAW_W'(med_val_q);
          out_smooth_d = smooth_q;
          out_mv_d     = mv_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acnt_q      <= '0;
      afull_q     <= 1'b0;
      k_q         <= '0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acnt_q      <= acnt_d;
      afull_q     <= afull_d;
      k_q         <= k_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q       <= samp_d;
    med_val_q    <= med_val_d;
    aw_q         <= aw_d;
    acc_q        <= acc_d;
    wsum_q       <= wsum_d;
    smooth_q     <= smooth_d;
    vprod_q      <= vprod_d;
    mv_q         <= mv_d;
    out_raw_q    <= out_raw_d;
    out_med_q    <= out_med_d;
    out_smooth_q <= out_smooth_d;
    out_mv_q     <= out_mv_d;
  end

  assign out_valid_o      = out_valid_q;
  assign raw_echo_o       = out_raw_q;
  assign median_value_o   = out_med_q;
  assign smoothed_value_o = out_smooth_q;
  assign voltage_mv_o     = out_mv_q;

endmodule
